// ----- sv/mac_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving average crossover package
// Field widths, register map, reset values and result codes shared by the
// interfaces and the crossover unit.
// ----------------------------------------------------------------------------
package mac_pkg;

   // item field widths
   localparam int CLOSE_W = 32;
   localparam int STAMP_W = 32;
   localparam int CASH_W  = 48;
   localparam int HELD_W  = 32;
   localparam int QTY_W   = 16;
   localparam int ACT_W   = 2;

   // configuration registers
   localparam int SHORT_LEN_W = 7;
   localparam int LONG_LEN_W  = 9;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [SHORT_LEN_W-1:0] SHORT_LEN_RESET = 7'd10;
   localparam logic [LONG_LEN_W-1:0]  LONG_LEN_RESET  = 9'd50;
   localparam logic [QTY_W-1:0]       ORDER_QTY_RESET = 16'd100;

   typedef enum logic [1:0] {
      CSR_SHORT_LEN = 2'd0,
      CSR_LONG_LEN  = 2'd1,
      CSR_ORDER_QTY = 2'd2
   } csr_idx_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE = 2'd0,
      ACT_BUY  = 2'd1,
      ACT_SELL = 2'd2
   } act_type;

   typedef enum logic [1:0] {
      REL_EQUAL = 2'd0,
      REL_ABOVE = 2'd1,
      REL_BELOW = 2'd2
   } rel_type;

endpackage

// ----- sv/mac_if.sv -----
// ----------------------------------------------------------------------------
// Moving average crossover channels
// Bar channel into the unit and order channel out of it, valid/ready.
// ----------------------------------------------------------------------------
interface mac_req_if
   import mac_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CLOSE_W-1:0]       close_price;
   logic [STAMP_W-1:0]       bar_stamp;
   logic [CASH_W-1:0]        cash_available;
   logic signed [HELD_W-1:0] shares_held;

   modport source (output valid, close_price, bar_stamp, cash_available, shares_held,
                   input ready);
   modport sink   (input valid, close_price, bar_stamp, cash_available, shares_held,
                   output ready);
endinterface

interface mac_rsp_if
   import mac_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [ACT_W-1:0]   action;
   logic [QTY_W-1:0]   order_shares;
   logic [CLOSE_W-1:0] order_price;
   logic [STAMP_W-1:0] order_stamp;

   modport source (output valid, action, order_shares, order_price, order_stamp,
                   input ready);
   modport sink   (input valid, action, order_shares, order_price, order_stamp,
                   output ready);
endinterface

// ----- sv/moving_average_crossover_signal_unit.sv -----
// ----------------------------------------------------------------------------
// Moving average crossover signal unit
// Keeps short and long ring windows of close prices with running sums,
// compares the averages by cross-multiplication and issues buy or sell
// orders on a crossing. One result item per bar.
// ----------------------------------------------------------------------------
// A result passes through stage 1, stage 2 and the result register.
// Throughput: one bar per cycle while the order channel takes results; the
// running-sum update around the ring RAM read is the loop that sets it.
// Reset (synchronous): lengths 10/50, order quantity 100, windows empty,
// no crossing history. Ring RAMs are not swept; fill counts guard them.
// ----------------------------------------------------------------------------
module moving_average_crossover_signal_unit
   import mac_pkg::*;
#(
   parameter int SHORT_MAX  = 64,
   parameter int LONG_MAX   = 256,
   parameter int PRICE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   mac_req_if.sink               req_if,
   mac_rsp_if.source             rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SLEN_W  = $clog2(SHORT_MAX + 1);
   localparam int LLEN_W  = $clog2(LONG_MAX + 1);
   localparam int SADDR_W = (SHORT_MAX > 1) ? $clog2(SHORT_MAX) : 1;
   localparam int LADDR_W = (LONG_MAX > 1) ? $clog2(LONG_MAX) : 1;
   localparam int SSUM_W  = PRICE_BITS + SLEN_W;
   localparam int LSUM_W  = PRICE_BITS + LLEN_W;
   localparam int PROD_W  = PRICE_BITS + SLEN_W + LLEN_W;
   localparam int COST_W  = PRICE_BITS + QTY_W;
   localparam int CMP_W   = (CASH_W > COST_W) ? CASH_W : COST_W;

   // ---------------------------------------------------------------- config
   logic [SHORT_LEN_W-1:0] short_len_ff, short_len_in;
   logic [LONG_LEN_W-1:0]  long_len_ff, long_len_in;
   logic [QTY_W-1:0]       qty_ff, qty_in;
   logic                   cfg_wr;
   logic                   clr_short;
   logic                   clr_long;
   logic [1:0]             csr_idx;
   logic [SLEN_W-1:0]      slen;
   logic [LLEN_W-1:0]      llen;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      short_len_in = short_len_ff;
      long_len_in  = long_len_ff;
      qty_in       = qty_ff;
      clr_short    = 1'b0;
      clr_long     = 1'b0;
      prdata       = '0;
      unique case (csr_idx)
         CSR_SHORT_LEN: begin
            prdata = CSR_DATA_W'(short_len_ff);
            if (cfg_wr) begin
               short_len_in = pwdata[SHORT_LEN_W-1:0];
               clr_short    = 1'b1;
            end
         end
         CSR_LONG_LEN: begin
            prdata = CSR_DATA_W'(long_len_ff);
            if (cfg_wr) begin
               long_len_in = pwdata[LONG_LEN_W-1:0];
               clr_long    = 1'b1;
            end
         end
         CSR_ORDER_QTY: begin
            prdata = CSR_DATA_W'(qty_ff);
            if (cfg_wr) begin
               qty_in = pwdata[QTY_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // effective window lengths: zero acts as one, clamp at the maximum
   always_comb begin
      if (short_len_ff == '0) begin
         slen = SLEN_W'(1);
      end else if (32'(short_len_ff) > 32'(SHORT_MAX)) begin
         slen = SLEN_W'(SHORT_MAX);
      end else begin
         slen = SLEN_W'(short_len_ff);
      end
      if (long_len_ff == '0) begin
         llen = LLEN_W'(1);
      end else if (32'(long_len_ff) > 32'(LONG_MAX)) begin
         llen = LLEN_W'(LONG_MAX);
      end else begin
         llen = LLEN_W'(long_len_ff);
      end
   end

   // ---------------------------------------------------------------- flow
   logic p1_vld_ff, p1_vld_in;
   logic p2_vld_ff, p2_vld_in;
   logic out_vld_ff, out_vld_in;
   logic out_free, p2_free, p1_free, p2_go, p1_go, accept;

   assign out_free     = !out_vld_ff || rsp_if.ready;
   assign p2_go        = p2_vld_ff && out_free;
   assign p2_free      = !p2_vld_ff || out_free;
   assign p1_go        = p1_vld_ff && p2_free;
   assign p1_free      = !p1_vld_ff || p2_free;
   // hold off the bar channel while reset is asserted
   assign req_if.ready = p1_free && !reset;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      p1_vld_in  = accept ? 1'b1 : (p1_go ? 1'b0 : p1_vld_ff);
      p2_vld_in  = p1_go ? 1'b1 : (p2_go ? 1'b0 : p2_vld_ff);
      out_vld_in = p2_go ? 1'b1 : (rsp_if.ready ? 1'b0 : out_vld_ff);
   end

   // ---------------------------------------------------------------- windows
   logic [PRICE_BITS-1:0] price;
   logic [PRICE_BITS-1:0] p1_price_ff;

   logic [SADDR_W-1:0]    s_ptr_ff, s_ptr_in;
   logic [SLEN_W-1:0]     s_fill_ff, s_fill_in;
   logic [SSUM_W-1:0]     s_sum_ff, s_sum_in;
   logic                  s_byp_ff, s_byp_in;
   logic [PRICE_BITS-1:0] s_rdata, s_old;
   logic [SLEN_W-1:0]     s_ptr_inc;
   logic                  s_full_now;

   logic [LADDR_W-1:0]    l_ptr_ff, l_ptr_in;
   logic [LLEN_W-1:0]     l_fill_ff, l_fill_in;
   logic [LSUM_W-1:0]     l_sum_ff, l_sum_in;
   logic                  l_byp_ff, l_byp_in;
   logic [PRICE_BITS-1:0] l_rdata, l_old;
   logic [LLEN_W-1:0]     l_ptr_inc;
   logic                  l_full_now;

   assign price = PRICE_BITS'(req_if.close_price);

   // a write to the slot being read lands after the RAM's read; forward it
   assign s_old = s_byp_ff ? p1_price_ff : s_rdata;
   assign l_old = l_byp_ff ? p1_price_ff : l_rdata;

   assign s_full_now = s_fill_ff >= slen;
   assign l_full_now = l_fill_ff >= llen;
   assign s_ptr_inc  = SLEN_W'(s_ptr_ff) + SLEN_W'(1);
   assign l_ptr_inc  = LLEN_W'(l_ptr_ff) + LLEN_W'(1);

   always_comb begin
      s_ptr_in  = s_ptr_ff;
      s_fill_in = s_fill_ff;
      s_sum_in  = s_sum_ff;
      l_ptr_in  = l_ptr_ff;
      l_fill_in = l_fill_ff;
      l_sum_in  = l_sum_ff;
      if (accept) begin
         s_ptr_in = (s_ptr_inc >= slen) ? '0 : SADDR_W'(s_ptr_inc);
         l_ptr_in = (l_ptr_inc >= llen) ? '0 : LADDR_W'(l_ptr_inc);
         if (!s_full_now) begin
            s_fill_in = s_fill_ff + SLEN_W'(1);
         end
         if (!l_full_now) begin
            l_fill_in = l_fill_ff + LLEN_W'(1);
         end
         s_sum_in = s_sum_ff - (s_full_now ? SSUM_W'(s_old) : '0) + SSUM_W'(price);
         l_sum_in = l_sum_ff - (l_full_now ? LSUM_W'(l_old) : '0) + LSUM_W'(price);
      end
      if (clr_short) begin
         s_ptr_in  = '0;
         s_fill_in = '0;
         s_sum_in  = '0;
      end
      if (clr_long) begin
         l_ptr_in  = '0;
         l_fill_in = '0;
         l_sum_in  = '0;
      end
      s_byp_in = accept && (s_ptr_ff == s_ptr_in);
      l_byp_in = accept && (l_ptr_ff == l_ptr_in);
   end

   mac_ram #(.WIDTH(PRICE_BITS), .DEPTH(SHORT_MAX)) short_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (s_ptr_ff),
      .wr_data (price),
      .rd_addr (s_ptr_in),
      .rd_data (s_rdata)
   );

   mac_ram #(.WIDTH(PRICE_BITS), .DEPTH(LONG_MAX)) long_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (l_ptr_ff),
      .wr_data (price),
      .rd_addr (l_ptr_in),
      .rd_data (l_rdata)
   );

   // ---------------------------------------------------------------- stage 1
   logic                     p1_full_ff;
   logic [SSUM_W-1:0]        p1_s_sum_ff;
   logic [LSUM_W-1:0]        p1_l_sum_ff;
   logic [STAMP_W-1:0]       p1_stamp_ff;
   logic [CASH_W-1:0]        p1_cash_ff;
   logic signed [HELD_W-1:0] p1_held_ff;
   logic [COST_W-1:0]        p1_cost_ff;
   logic [COST_W-1:0]        cost;

   assign cost = {{QTY_W{1'b0}}, price} * {{PRICE_BITS{1'b0}}, qty_ff};

   // ---------------------------------------------------------------- stage 2
   logic [PROD_W-1:0]     p2_s_prod_ff, s_prod;
   logic [PROD_W-1:0]     p2_l_prod_ff, l_prod;
   logic                  p2_full_ff;
   logic                  p2_nz_ff;
   logic                  p2_buy_ok_ff, buy_ok;
   logic                  p2_sell_ok_ff, sell_ok;
   logic [QTY_W-1:0]      p2_cap_qty_ff, cap_qty;
   logic [PRICE_BITS-1:0] p2_price_ff;
   logic [STAMP_W-1:0]    p2_stamp_ff;

   assign s_prod = {{LLEN_W{1'b0}}, p1_s_sum_ff} * {{SSUM_W{1'b0}}, llen};
   assign l_prod = {{SLEN_W{1'b0}}, p1_l_sum_ff} * {{LSUM_W{1'b0}}, slen};
   assign buy_ok = CMP_W'(p1_cash_ff) > CMP_W'(p1_cost_ff);

   always_comb begin
      sell_ok = !p1_held_ff[HELD_W-1] && (p1_held_ff != '0);
      cap_qty = qty_ff;
      if (unsigned'(p1_held_ff) < HELD_W'(qty_ff)) begin
         cap_qty = p1_held_ff[QTY_W-1:0];
      end
   end

   // ---------------------------------------------------------------- result
   rel_type               prev_rel_ff, prev_rel_in, rel;
   logic                  prev_valid_ff, prev_valid_in;
   act_type               act_ff, act_in;
   logic [QTY_W-1:0]      shares_ff, shares_in;
   logic [CLOSE_W-1:0]    oprice_ff, oprice_in;
   logic [STAMP_W-1:0]    ostamp_ff, ostamp_in;

   always_comb begin
      if (p2_s_prod_ff > p2_l_prod_ff) begin
         rel = REL_ABOVE;
      end else if (p2_s_prod_ff < p2_l_prod_ff) begin
         rel = REL_BELOW;
      end else begin
         rel = REL_EQUAL;
      end
   end

   always_comb begin
      prev_rel_in   = prev_rel_ff;
      prev_valid_in = prev_valid_ff;
      act_in        = ACT_NONE;
      shares_in     = '0;
      if (p2_go && p2_full_ff) begin
         if (prev_valid_ff && (qty_ff != '0)) begin
            if ((prev_rel_ff != REL_ABOVE) && (rel == REL_ABOVE)) begin
               if (p2_buy_ok_ff) begin
                  act_in    = ACT_BUY;
                  shares_in = qty_ff;
               end
            end else if ((prev_rel_ff != REL_BELOW) && (rel == REL_BELOW)) begin
               if (p2_sell_ok_ff) begin
                  act_in    = ACT_SELL;
                  shares_in = p2_cap_qty_ff;
               end
            end
         end
         prev_rel_in   = rel;
         prev_valid_in = p2_nz_ff;
      end
      if (clr_short || clr_long) begin
         prev_valid_in = 1'b0;
      end
      oprice_in = (act_in != ACT_NONE) ? CLOSE_W'(p2_price_ff) : '0;
      ostamp_in = (act_in != ACT_NONE) ? p2_stamp_ff : '0;
   end

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.action       = act_ff;
   assign rsp_if.order_shares = shares_ff;
   assign rsp_if.order_price  = oprice_ff;
   assign rsp_if.order_stamp  = ostamp_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_len_ff  <= SHORT_LEN_RESET;
         long_len_ff   <= LONG_LEN_RESET;
         qty_ff        <= ORDER_QTY_RESET;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         out_vld_ff    <= 1'b0;
         s_ptr_ff      <= '0;
         s_fill_ff     <= '0;
         s_sum_ff      <= '0;
         s_byp_ff      <= 1'b0;
         l_ptr_ff      <= '0;
         l_fill_ff     <= '0;
         l_sum_ff      <= '0;
         l_byp_ff      <= 1'b0;
         prev_rel_ff   <= REL_EQUAL;
         prev_valid_ff <= 1'b0;
      end else begin
         short_len_ff  <= short_len_in;
         long_len_ff   <= long_len_in;
         qty_ff        <= qty_in;
         p1_vld_ff     <= p1_vld_in;
         p2_vld_ff     <= p2_vld_in;
         out_vld_ff    <= out_vld_in;
         s_ptr_ff      <= s_ptr_in;
         s_fill_ff     <= s_fill_in;
         s_sum_ff      <= s_sum_in;
         s_byp_ff      <= s_byp_in;
         l_ptr_ff      <= l_ptr_in;
         l_fill_ff     <= l_fill_in;
         l_sum_ff      <= l_sum_in;
         l_byp_ff      <= l_byp_in;
         prev_rel_ff   <= prev_rel_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_full_ff  <= (s_fill_in >= slen) && (l_fill_in >= llen);
         p1_s_sum_ff <= s_sum_in;
         p1_l_sum_ff <= l_sum_in;
         p1_price_ff <= price;
         p1_stamp_ff <= req_if.bar_stamp;
         p1_cash_ff  <= req_if.cash_available;
         p1_held_ff  <= req_if.shares_held;
         p1_cost_ff  <= cost;
      end
      if (p1_go) begin
         p2_s_prod_ff  <= s_prod;
         p2_l_prod_ff  <= l_prod;
         p2_full_ff    <= p1_full_ff;
         p2_nz_ff      <= (p1_s_sum_ff != '0) && (p1_l_sum_ff != '0);
         p2_buy_ok_ff  <= buy_ok;
         p2_sell_ok_ff <= sell_ok;
         p2_cap_qty_ff <= cap_qty;
         p2_price_ff   <= p1_price_ff;
         p2_stamp_ff   <= p1_stamp_ff;
      end
      if (p2_go) begin
         act_ff    <= act_in;
         shares_ff <= shares_in;
         oprice_ff <= oprice_in;
         ostamp_ff <= ostamp_in;
      end
   end

endmodule

// ----- sv/mac_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read returning the old data on
// a same-address write.
// ----------------------------------------------------------------------------
module mac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Moving average crossover unit testbench
// Drives bars into the unit, predicts the short/long window averages and
// the crossing orders, and checks every order item field by field. Runs on
// reset lengths, a directed set of tiny windows, random lengths and the
// widest windows, with idle cycles on both channels but in the widest run.
// ----------------------------------------------------------------------------
module testbench;
   import mac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SHORT_CAP    = 64;
   localparam int          LONG_CAP     = 256;
   localparam int          SHORT_WIN    = 0;
   localparam int          LONG_WIN     = 1;
   localparam int          SPARE_REG    = 3;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          STALL_LIMIT  = 4000;
   localparam logic [47:0] CASH_MAX     = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [CLOSE_W-1:0]       close;
      logic [STAMP_W-1:0]       stamp;
      logic [CASH_W-1:0]        cash;
      logic signed [HELD_W-1:0] held;
   } bar_type;

   typedef struct packed {
      act_type            action;
      logic [QTY_W-1:0]   shares;
      logic [CLOSE_W-1:0] price;
      logic [STAMP_W-1:0] stamp;
   } order_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mac_req_if bar_ch ();
   mac_rsp_if order_ch ();

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   logic    bar_valid   = 1'b0;
   logic    order_ready = 1'b0;
   bar_type cur_bar     = '0;

   assign bar_ch.valid          = bar_valid;
   assign bar_ch.close_price    = cur_bar.close;
   assign bar_ch.bar_stamp      = cur_bar.stamp;
   assign bar_ch.cash_available = cur_bar.cash;
   assign bar_ch.shares_held    = cur_bar.held;
   assign order_ch.ready        = order_ready;

   moving_average_crossover_signal_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (bar_ch),
      .rsp_if  (order_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   bar_type   bar_pending [$];
   order_type order_exp   [$];

   int send_idle_pct = 33;
   int recv_idle_pct = 65;
   int error_count   = 0;
   int bars_accepted = 0;
   int buys_seen     = 0;
   int sells_seen    = 0;
   int stall_cycles  = 0;

   // predictor state: registers and both windows
   logic [SHORT_LEN_W-1:0] short_len_reg = SHORT_LEN_RESET;
   logic [LONG_LEN_W-1:0]  long_len_reg  = LONG_LEN_RESET;
   logic [QTY_W-1:0]       qty_reg       = ORDER_QTY_RESET;
   logic [CLOSE_W-1:0]     win_ring [2][LONG_CAP];
   logic [63:0]            win_sum  [2];
   int unsigned            win_fill [2];
   int unsigned            win_ptr  [2];
   rel_type                last_rel   = REL_EQUAL;
   bit                     last_valid = 1'b0;

   // price walk used by the random bars
   longint walk_price = 100000;
   int     walk_drift = 0;
   int     walk_left  = 0;

   function automatic void clear_window(int w);
      for (int i = 0; i < LONG_CAP; i++) win_ring[w][i] = '0;
      win_sum[w]  = '0;
      win_fill[w] = 0;
      win_ptr[w]  = 0;
   endfunction

   function automatic int unsigned eff_len(int unsigned v, int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
   endfunction

   function automatic order_type crossover_predict(bar_type b);
      order_type   o;
      int unsigned len [2];
      int unsigned p;
      logic [63:0] lhs;
      logic [63:0] rhs;
      rel_type     rel;
      o.action = ACT_NONE;
      o.shares = '0;
      o.price  = '0;
      o.stamp  = '0;
      len[SHORT_WIN] = eff_len(32'(short_len_reg), SHORT_CAP);
      len[LONG_WIN]  = eff_len(32'(long_len_reg), LONG_CAP);
      for (int w = 0; w < 2; w++) begin
         p = win_ptr[w];
         if (p >= len[w]) p = 0;
         // full window: drop the oldest price from the sum
         if (win_fill[w] >= len[w]) win_sum[w] -= 64'(win_ring[w][p]);
         else win_fill[w]++;
         win_ring[w][p] = b.close;
         win_sum[w] += 64'(b.close);
         p++;
         win_ptr[w] = (p >= len[w]) ? 0 : p;
      end
      if (win_fill[SHORT_WIN] >= len[SHORT_WIN] && win_fill[LONG_WIN] >= len[LONG_WIN]) begin
         lhs = win_sum[SHORT_WIN] * 64'(len[LONG_WIN]);
         rhs = win_sum[LONG_WIN] * 64'(len[SHORT_WIN]);
         rel = (lhs > rhs) ? REL_ABOVE : (lhs < rhs) ? REL_BELOW : REL_EQUAL;
         if (last_valid && qty_reg != 0) begin
            if (last_rel != REL_ABOVE && rel == REL_ABOVE) begin
               if (64'(b.cash) > 64'(b.close) * 64'(qty_reg)) begin
                  o.action = ACT_BUY;
                  o.shares = qty_reg;
               end
            end else if (last_rel != REL_BELOW && rel == REL_BELOW) begin
               if (b.held > 0) begin
                  o.action = ACT_SELL;
                  o.shares = ($unsigned(b.held) < 32'(qty_reg)) ? b.held[QTY_W-1:0] : qty_reg;
               end
            end
         end
         last_rel   = rel;
         last_valid = (win_sum[SHORT_WIN] != 0) && (win_sum[LONG_WIN] != 0);
      end
      if (o.action != ACT_NONE) begin
         o.price = b.close;
         o.stamp = b.stamp;
      end
      return o;
   endfunction

   function automatic void apply_reg(int idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SHORT_LEN: begin
            short_len_reg = data[SHORT_LEN_W-1:0];
            clear_window(SHORT_WIN);
            last_valid = 1'b0;
         end
         CSR_LONG_LEN: begin
            long_len_reg = data[LONG_LEN_W-1:0];
            clear_window(LONG_WIN);
            last_valid = 1'b0;
         end
         CSR_ORDER_QTY: qty_reg = data[QTY_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic bar_type next_walk_bar();
      bar_type     b;
      logic [63:0] cost;
      if (walk_left == 0) begin
         walk_left  = $urandom_range(4, 60);
         walk_drift = $urandom_range(1, 400);
         if ($urandom_range(0, 1) == 0) walk_drift = -walk_drift;
      end
      walk_left--;
      b.stamp = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any price, cash and position
         b.close = $urandom;
         b.cash  = CASH_W'({$urandom, $urandom});
         b.held  = $urandom;
      end else begin
         walk_price += longint'(walk_drift) + longint'($urandom_range(0, 400)) - 200;
         if (walk_price < 1000) begin
            walk_price = 1000;
            walk_drift = $urandom_range(1, 400);
         end else if (walk_price > 64'd2000000000) begin
            walk_price = 2000000000;
            walk_drift = -int'($urandom_range(1, 400));
         end
         b.close = walk_price[CLOSE_W-1:0];
         cost = 64'(b.close) * 64'(qty_reg);
         case ($urandom_range(0, 3))
            0: b.cash = cost[CASH_W-1:0];
            1: b.cash = CASH_W'({$urandom, $urandom} >> $urandom_range(0, 47));
            default: b.cash = CASH_MAX - 48'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: b.held = $urandom_range(1, 200);
            1: b.held = -int'($urandom_range(0, 1000));
            2: b.held = $urandom_range(1, 200000);
            default: b.held = $urandom;
         endcase
      end
      return b;
   endfunction

   function automatic void add_bar(logic [CLOSE_W-1:0] close, logic [CASH_W-1:0] cash,
                                   int held);
      bar_type b;
      b.close = close;
      b.stamp = $urandom;
      b.cash  = cash;
      b.held  = held;
      bar_pending = {bar_pending, b};
   endfunction

   function automatic void add_walk_bars(int n);
      repeat (n) bar_pending = {bar_pending, next_walk_bar()};
   endfunction

   task automatic flag_error(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic csr_write(int idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx * 4);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      apply_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (bar_pending.size() != 0 || bar_valid || order_exp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // bar driver: predict on each accepted item, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         bar_valid <= 1'b0;
      end else begin
         if (bar_valid && bar_ch.ready) begin
            order_exp = {order_exp, crossover_predict(cur_bar)};
            bars_accepted++;
         end
         if (!bar_valid || bar_ch.ready) begin
            if (bar_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_bar   <= bar_pending.pop_front();
               bar_valid <= 1'b1;
            end else begin
               bar_valid <= 1'b0;
            end
         end
      end
   end

   // order monitor
   always @(posedge clock) begin
      order_type want;
      if (reset) begin
         order_ready <= 1'b0;
      end else begin
         if (order_ch.valid && order_ready) begin
            if (order_exp.size() == 0) begin
               flag_error("order item with no bar outstanding", 64'(order_ch.action), 0);
            end else begin
               want = order_exp.pop_front();
               if (order_ch.action !== want.action)
                  flag_error("action", 64'(order_ch.action), 64'(want.action));
               if (order_ch.order_shares !== want.shares)
                  flag_error("order_shares", 64'(order_ch.order_shares), 64'(want.shares));
               if (order_ch.order_price !== want.price)
                  flag_error("order_price", 64'(order_ch.order_price), 64'(want.price));
               if (order_ch.order_stamp !== want.stamp)
                  flag_error("order_stamp", 64'(order_ch.order_stamp), 64'(want.stamp));
               if (want.action == ACT_BUY) buys_seen++;
               if (want.action == ACT_SELL) sells_seen++;
            end
         end
         order_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (bar_valid && bar_ch.ready) || (order_ch.valid && order_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TIMEOUT: no item moved for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      clear_window(SHORT_WIN);
      clear_window(LONG_WIN);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset lengths and quantity
      add_walk_bars(120);
      wait_idle();

      // tiny windows: short 1, long 2, so a turn between up and down bars is a cross
      csr_write(CSR_SHORT_LEN, 32'd1);
      csr_write(CSR_LONG_LEN, 32'd2);
      csr_write(CSR_ORDER_QTY, 32'hFFFF);
      add_bar(0, CASH_MAX, 1);
      add_bar(0, CASH_MAX, 1);
      add_bar(5, CASH_MAX, 1);
      add_bar(3, CASH_MAX, -1);
      add_bar(8, 0, 5);
      add_bar(2, CASH_MAX, 0);
      add_bar(9, 48'(64'd9 * 64'hFFFF), 5);
      add_bar(1, 0, 7);
      add_bar(32'hFFFF_FFFF, CASH_MAX, 5);
      add_bar(0, CASH_MAX, 32'h7FFF_FFFF);
      add_bar(0, CASH_MAX, 1);
      add_bar(4, CASH_MAX, 1);
      add_bar(4, CASH_MAX, 1);
      add_bar(2, CASH_MAX, 32'h8000_0000);
      add_bar(6, CASH_MAX, 1);
      add_bar(1, CASH_MAX, 100);
      wait_idle();

      // zero quantity suppresses every order
      csr_write(CSR_ORDER_QTY, 32'h1234_0000);
      add_bar(5, CASH_MAX, 50);
      add_bar(1, CASH_MAX, 50);
      add_bar(5, CASH_MAX, 50);
      add_bar(1, CASH_MAX, 50);
      wait_idle();

      // zero lengths act as one: averages always equal
      csr_write(CSR_SHORT_LEN, 32'hFFFF_FF80);
      csr_write(CSR_LONG_LEN, 32'hFFFF_FE00);
      csr_write(CSR_ORDER_QTY, 32'd10);
      add_bar(7, CASH_MAX, 50);
      add_bar(1, CASH_MAX, 50);
      add_bar(9, CASH_MAX, 50);
      wait_idle();

      // random lengths, swapped idling, and a write past the register map
      send_idle_pct = 65;
      recv_idle_pct = 33;
      csr_write(CSR_SHORT_LEN, ($urandom << SHORT_LEN_W) | $urandom_range(1, 20));
      csr_write(CSR_LONG_LEN, ($urandom << LONG_LEN_W) | $urandom_range(1, 40));
      csr_write(CSR_ORDER_QTY, $urandom_range(1, 500));
      csr_write(SPARE_REG, $urandom);
      add_walk_bars(120);
      wait_idle();

      // out-of-range lengths clamp to the widest windows, no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(CSR_SHORT_LEN, 32'h7F);
      csr_write(CSR_LONG_LEN, 32'h1FF);
      csr_write(CSR_ORDER_QTY, $urandom_range(1, 1000));
      add_walk_bars(290);
      wait_idle();

      if (order_exp.size() != 0)
         flag_error("orders never received", 64'(order_exp.size()), 0);
      $display("Covered %0d bars over reset, tiny, zero, random and widest window settings,",
               bars_accepted);
      $display("with %0d buy and %0d sell orders checked", buys_seen, sells_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
